FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the priority queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SPQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the default clock and reset port names.
`define SPQ_ASSERT(lbl, prop, msg) \
  `SPQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Default sizes, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEF      = 16;
  localparam int unsigned DATA_BITS_DEF     = 32;
  localparam int unsigned PRIORITY_BITS_DEF = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: sv/stable_priority_queue.sv
// A result beat is registered and shows in the cycle after its command beat is accepted.
// One command beat per cycle unless stalled; all cells compare and shift in the same cycle.
// The cycle is set by one priority compare per cell plus the select of its next value.
// Reset clears the occupancy count and the output valid; slot contents are not cleared
// and slots at or above the occupancy count are never read.
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded sorted queue built as a chain of cells, highest priority at cell 0.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int unsigned CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_BITS     = spq_pkg::DATA_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [DATA_BITS-1:0]     entry_data_i,
  input  logic [PRIORITY_BITS-1:0] entry_priority_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [DATA_BITS-1:0]     front_data_o,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         fill_count_o
);

  // The input side stalls only while a finished result is held back downstream,
  // so an unblocked output register lets a new command beat in every cycle.
  logic out_valid_q, out_valid_d;
  logic accept;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  logic [CNT_W-1:0] occ_q, occ_d;
  logic             full, empty;
  assign full  = (occ_q == CNT_W'(CAPACITY));
  assign empty = (occ_q == '0);

  // Command decode. An insert into a full queue and a remove from an empty one
  // leave every cell untouched.
  spq_pkg::cell_ctrl_t ctrl;
  logic                is_remove;
  assign is_remove = (cmd_i == spq_pkg::CMD_REMOVE);
  assign ctrl.ins  = accept && !is_remove && !full;
  assign ctrl.rem  = accept && is_remove && !empty;

  // Cell chain. Each cell sees its upper neighbor (toward the front) for
  // inserts and its lower neighbor for removes.
  logic [DATA_BITS-1:0]     cell_data [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
  logic                     cell_ge   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_ge;
    logic [DATA_BITS-1:0]     prev_data, next_data;
    logic [PRIORITY_BITS-1:0] prev_prio, next_prio;

    if (i == 0) begin : g_front
      // Nothing is ahead of the front cell, so it loads the new entry when it yields.
      assign prev_ge   = 1'b1;
      assign prev_data = entry_data_i;
      assign prev_prio = entry_priority_i;
    end else begin : g_mid
      assign prev_ge   = cell_ge[i-1];
      assign prev_data = cell_data[i-1];
      assign prev_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      // The back cell becomes unused on a remove; its content does not matter.
      assign next_data = cell_data[i];
      assign next_prio = cell_prio[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
      assign next_prio = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_BITS     (DATA_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (CNT_W'(i) < occ_q),
      .new_data_i  (entry_data_i),
      .new_prio_i  (entry_priority_i),
      .prev_ge_i   (prev_ge),
      .prev_data_i (prev_data),
      .prev_prio_i (prev_prio),
      .next_data_i (next_data),
      .next_prio_i (next_prio),
      .ge_o        (cell_ge[i]),
      .data_o      (cell_data[i]),
      .prio_o      (cell_prio[i])
    );
  end

  // Result of the current beat, computed from the state before the update.
  logic [DATA_BITS-1:0] front_data_q, front_data_d;
  spq_pkg::status_e     status_q, status_d;
  logic [CNT_W-1:0]     fill_count_q, fill_count_d;

  always_comb begin
    occ_d        = occ_q;
    front_data_d = front_data_q;
    status_d     = status_q;
    fill_count_d = fill_count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d  = 1'b1;
      front_data_d = '0;
      status_d     = spq_pkg::STATUS_DONE;
      if (is_remove) begin
        if (empty) begin
          status_d = spq_pkg::STATUS_EMPTY;
        end else begin
          front_data_d = cell_data[0];
          occ_d        = occ_q - CNT_W'(1);
        end
      end else begin
        if (full) begin
          status_d = spq_pkg::STATUS_FULL;
        end else begin
          occ_d = occ_q + CNT_W'(1);
        end
      end
      fill_count_d = occ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_data_q <= front_data_d;
    status_q     <= status_d;
    fill_count_q <= fill_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign front_data_o = front_data_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_count_q;

endmodule

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain: keeps, loads the new entry, or takes a neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned DATA_BITS     = spq_pkg::DATA_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk_i,
  input  spq_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     valid_i,
  input  logic [DATA_BITS-1:0]     new_data_i,
  input  logic [PRIORITY_BITS-1:0] new_prio_i,
  input  logic                     prev_ge_i,
  input  logic [DATA_BITS-1:0]     prev_data_i,
  input  logic [PRIORITY_BITS-1:0] prev_prio_i,
  input  logic [DATA_BITS-1:0]     next_data_i,
  input  logic [PRIORITY_BITS-1:0] next_prio_i,
  output logic                     ge_o,
  output logic [DATA_BITS-1:0]     data_o,
  output logic [PRIORITY_BITS-1:0] prio_o
);

  logic [DATA_BITS-1:0]     data_q, data_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;

  // A valid slot at or above the new priority stays ahead of the new entry.
  assign ge_o = valid_i && (prio_q >= new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.ins) begin
      if (!ge_o) begin
        if (prev_ge_i) begin
          data_d = new_data_i;
          prio_d = new_prio_i;
        end else begin
          data_d = prev_data_i;
          prio_d = prev_prio_i;
        end
      end
    end else if (ctrl_i.rem) begin
      data_d = next_data_i;
      prio_d = next_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

FILE: sv/spq_checker.sv
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level assertions on the queue's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker #(
  parameter int unsigned CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_BITS     = spq_pkg::DATA_BITS_DEF,
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [DATA_BITS-1:0]     front_data_o,
  input logic [1:0]               status_o,
  input logic [CNT_W-1:0]         fill_count_o
);

  // A held result beat keeps its payload.
  `SPQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> $stable(front_data_o) && $stable(status_o) && $stable(fill_count_o), "stalled result beat changed")

  // A dropped insert is only reported by a full queue.
  `SPQ_ASSERT(a_full_count, out_valid_o && status_o == spq_pkg::STATUS_FULL |-> fill_count_o == CNT_W'(CAPACITY), "full status without full count")

  // An empty remove reports no data and no entries.
  `SPQ_ASSERT(a_empty_zero, out_valid_o && status_o == spq_pkg::STATUS_EMPTY |-> fill_count_o == '0 && front_data_o == '0, "empty status with data or entries")

  // The count never passes the capacity.
  `SPQ_ASSERT(a_count_max, out_valid_o |-> fill_count_o <= CNT_W'(CAPACITY), "fill count above capacity")

  // The input side only stalls behind a waiting result beat.
  `SPQ_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a held result")

endmodule

bind stable_priority_queue spq_checker #(
  .CAPACITY      (CAPACITY),
  .DATA_BITS     (DATA_BITS)
) u_spq_checker (.*);
